@@ design/ppe_pkg.sv @@
// Package for the postfix expression evaluator: widths, character codes,
// status codes, controller states and the stack cell control struct.
// No dependencies.
package ppe_pkg;

  localparam int unsigned PPE_DATA_W      = 32;
  localparam int unsigned PPE_CHAR_W      = 8;
  localparam int unsigned PPE_STATUS_W    = 3;
  localparam int unsigned PPE_STACK_DEPTH = 16;

  // Character codes
  localparam logic [PPE_CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [PPE_CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [PPE_CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [PPE_CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [PPE_CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [PPE_CHAR_W-1:0] CH_NINE  = 8'd57;

  // Status codes
  localparam logic [PPE_STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [PPE_STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [PPE_STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [PPE_STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [PPE_STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FINISH
  } ppe_state_e;

  // Per-cell move: take the neighbor above (push) or below (pop).
  typedef struct packed {
    logic take_above;
    logic take_below;
  } ppe_cell_ctl_t;

endpackage

@@ design/ppe_in_if.sv @@
// Input channel of the postfix expression evaluator: one character per item.
// Depends on ppe_pkg.
interface ppe_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppe_pkg::PPE_CHAR_W-1:0] char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ design/ppe_out_if.sv @@
// Output channel of the postfix expression evaluator: value and status.
// Depends on ppe_pkg.
interface ppe_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ppe_pkg::PPE_DATA_W-1:0]  result_value;
  logic [ppe_pkg::PPE_STATUS_W-1:0]       status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

@@ design/ppe_stack_cell.sv @@
// One entry of the shift-register value stack.
// Depends on ppe_pkg.
module ppe_stack_cell (
  input  logic                            clk_i,
  input  ppe_pkg::ppe_cell_ctl_t          ctl_i,
  input  logic [ppe_pkg::PPE_DATA_W-1:0]  above_i,
  input  logic [ppe_pkg::PPE_DATA_W-1:0]  below_i,
  output logic [ppe_pkg::PPE_DATA_W-1:0]  value_o
);
  import ppe_pkg::*;

  logic [PPE_DATA_W-1:0] value_q;
  logic [PPE_DATA_W-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.take_above) begin
      value_d = above_i;
    end else if (ctl_i.take_below) begin
      value_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ design/ppe_div_unit.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ppe_pkg.
module ppe_div_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ppe_pkg::PPE_DATA_W-1:0]  dividend_i,
  input  logic [ppe_pkg::PPE_DATA_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [ppe_pkg::PPE_DATA_W-1:0]  quotient_o
);
  import ppe_pkg::*;

  localparam int unsigned StepW = $clog2(PPE_DATA_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [PPE_DATA_W-1:0] rem_q, rem_d;
  logic [PPE_DATA_W-1:0] quo_q, quo_d;
  logic [PPE_DATA_W-1:0] den_q, den_d;
  logic [PPE_DATA_W:0]   shifted;
  logic [PPE_DATA_W:0]   trial;

  always_comb begin
    shifted = {rem_q, quo_q[PPE_DATA_W-1]};
    trial   = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      // subtract when the trial remainder stays non-negative
      if (!trial[PPE_DATA_W]) begin
        rem_d = trial[PPE_DATA_W-1:0];
        quo_d = {quo_q[PPE_DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[PPE_DATA_W-1:0];
        quo_d = {quo_q[PPE_DATA_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(PPE_DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ design/postfix_expression_evaluator_core.sv @@
// Postfix expression evaluator: takes one character of a postfix expression
// per item and, on the item marked last, returns the top of stack and a status
// (0 ok, 1 overflow, 2 underflow, 3 divide by zero, 4 empty at end; the first
// error of an expression is the one reported). The value stack is a row of
// STACK_DEPTH shift cells with the top in cell 0: a push moves every entry one
// cell down, an operator puts its result in cell 0 and moves the rest up.
// A digit, an ignored character, '+', '-', '*' or a division by zero is
// accepted, then executed; a division by a nonzero operand also waits for the
// iterative divider, which yields one quotient bit per cycle over 32 bits. A
// last character then passes a finish state that loads the output register,
// which waits while the result is still held there. Division truncates toward
// zero; all arithmetic wraps at 32 bits. No clearing pass is needed after reset.
// Depends on ppe_pkg, ppe_in_if, ppe_out_if, ppe_stack_cell and ppe_div_unit.
module postfix_expression_evaluator_core #(
  parameter int unsigned STACK_DEPTH = ppe_pkg::PPE_STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppe_in_if.sink    in_i,
  ppe_out_if.source out_o
);
  import ppe_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  // Controller and item registers
  ppe_state_e              state_q, state_d;
  logic [PPE_CHAR_W-1:0]   char_q;
  logic                    last_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [PPE_STATUS_W-1:0] err_q, err_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [PPE_DATA_W-1:0]   out_value_q, out_value_d;
  logic [PPE_STATUS_W-1:0] out_status_q, out_status_d;
  logic                    out_free;

  // Stack cells
  ppe_cell_ctl_t           cell_ctl [STACK_DEPTH];
  logic [PPE_DATA_W-1:0]   cell_val [STACK_DEPTH];
  logic [PPE_DATA_W-1:0]   top_in;

  // Datapath
  logic                    is_digit;
  logic                    is_op;
  logic                    is_slash;
  logic                    stack_full;
  logic                    op_uflow;
  logic [PPE_DATA_W-1:0]   right_v;
  logic [PPE_DATA_W-1:0]   left_v;
  logic [PPE_DATA_W-1:0]   prod;
  logic [PPE_DATA_W-1:0]   quo_fixed;
  logic [PPE_DATA_W-1:0]   op_res;
  logic [PPE_DATA_W-1:0]   digit_v;
  logic                    div_go;

  // Divider
  logic                    div_start;
  logic                    div_done;
  logic [PPE_DATA_W-1:0]   div_num;
  logic [PPE_DATA_W-1:0]   div_den;
  logic [PPE_DATA_W-1:0]   div_quo;

  // Stack moves
  logic                    do_push;
  logic                    do_commit;

  function automatic logic [PPE_STATUS_W-1:0] keep_first(
    input logic [PPE_STATUS_W-1:0] held,
    input logic [PPE_STATUS_W-1:0] code
  );
    keep_first = (held == ST_OK) ? code : held;
  endfunction

  // ---------------------------------------------------------------------
  // Operand fetch and arithmetic; missing operands read as zero
  // ---------------------------------------------------------------------
  always_comb begin
    is_digit   = char_q inside {[CH_ZERO:CH_NINE]};
    is_op      = char_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    is_slash   = (char_q == CH_SLASH);
    stack_full = (cnt_q == CntW'(STACK_DEPTH));
    op_uflow   = (cnt_q < CntW'(2));
    right_v    = (cnt_q != '0) ? cell_val[0] : '0;
    left_v     = op_uflow ? '0 : cell_val[1];
    digit_v    = PPE_DATA_W'(char_q - CH_ZERO);
    // only the low word of the product is kept
    prod       = left_v * right_v;
    quo_fixed  = (left_v[PPE_DATA_W-1] ^ right_v[PPE_DATA_W-1]) ? (~div_quo + 1'b1)
                                                                   : div_quo;
    div_num    = left_v[PPE_DATA_W-1] ? (~left_v + 1'b1) : left_v;
    div_den    = right_v[PPE_DATA_W-1] ? (~right_v + 1'b1) : right_v;
    // a division by a nonzero operand goes to the divider
    div_go     = is_slash && (right_v != '0);
    case (char_q)
      CH_PLUS:  op_res = left_v + right_v;
      CH_MINUS: op_res = left_v - right_v;
      CH_STAR:  op_res = prod;
      CH_SLASH: op_res = (right_v == '0) ? '0 : quo_fixed;
      default:  op_res = '0;
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_op && div_go) begin
          state_d = S_DIV;
        end else begin
          state_d = last_q ? S_FINISH : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = last_q ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Controller outputs: stack moves, count, sticky error, output load
  // ---------------------------------------------------------------------
  always_comb begin
    in_i.ready   = 1'b0;
    do_push      = 1'b0;
    do_commit    = 1'b0;
    div_start    = 1'b0;
    cnt_d        = cnt_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
      end
      S_EXEC: begin
        if (is_digit) begin
          // drop the digit when the stack is full
          if (stack_full) begin
            err_d = keep_first(err_q, ST_OVERFLOW);
          end else begin
            do_push = 1'b1;
          end
        end else if (is_op) begin
          if (div_go) begin
            div_start = 1'b1;
            if (op_uflow) begin
              err_d = keep_first(err_q, ST_UNDERFLOW);
            end
          end else begin
            do_commit = 1'b1;
          end
        end
      end
      S_DIV: begin
        do_commit = div_done;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = (cnt_q != '0) ? cell_val[0] : '0;
          out_status_d = (cnt_q == '0) ? keep_first(err_q, ST_EMPTY) : err_q;
          cnt_d        = '0;
          err_d        = ST_OK;
        end
      end
      default: ;
    endcase

    if (do_push) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (do_commit) begin
      // pop two, push one: with fewer than two entries the result stands alone
      cnt_d = op_uflow ? CntW'(1) : cnt_q - 1'b1;
      if (op_uflow) begin
        err_d = keep_first(err_q, ST_UNDERFLOW);
      end else if (is_slash && (right_v == '0)) begin
        err_d = keep_first(err_q, ST_DIVZERO);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stack: row of shift cells, cell 0 on top
  // ---------------------------------------------------------------------
  assign top_in = do_push ? digit_v : op_res;

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [PPE_DATA_W-1:0] above;
    logic [PPE_DATA_W-1:0] below;

    if (g == 0) begin : g_top
      assign above = top_in;
      assign cell_ctl[g].take_above = do_push || do_commit;
      assign cell_ctl[g].take_below = 1'b0;
    end else begin : g_rest
      assign above = cell_val[g-1];
      assign cell_ctl[g].take_above = do_push;
      assign cell_ctl[g].take_below = do_commit;
    end

    if (g == STACK_DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_inner
      assign below = cell_val[g+1];
    end

    ppe_stack_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[g]),
      .above_i (above),
      .below_i (below),
      .value_o (cell_val[g])
    );
  end

  ppe_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the accepted item until it is executed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_code;
      last_q <= in_i.last_char;
    end
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.status       = out_status_q;

endmodule

@@ tb/postfix_expression_evaluator_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for postfix_expression_evaluator_core: streams postfix
// expressions one character per item and checks every value/status result against a
// stack predictor in the bench. Depends on the core, ppe_pkg, ppe_in_if, ppe_out_if.
module postfix_expression_evaluator_core_test;
  import ppe_pkg::*;

  typedef struct packed {
    logic [PPE_CHAR_W-1:0] code;
    logic                  last;
  } char_item_t;

  typedef struct packed {
    logic [PPE_DATA_W-1:0]   value;
    logic [PPE_STATUS_W-1:0] status;
  } rpn_result_t;

  // Clock, reset and the registers behind the block's inputs. The initializers
  // give every input a known value from time zero, before the first edge.
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       send_valid = 1'b0;
  char_item_t send_item  = '0;
  logic       take_ready = 1'b0;

  // Idle percentages for each side, and the hold that stops the sender.
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 83;
  logic        pause_sender  = 1'b0;

  char_item_t  char_queue[$];         // characters waiting to be sent
  char_item_t  draft[$];              // expression under construction
  rpn_result_t expected_results[$];   // value/status still owed by the block

  // Predictor state: a copy of the value stack, its fill and the held error.
  logic [PPE_DATA_W-1:0]   rpn_stack [PPE_STACK_DEPTH];
  int unsigned             rpn_depth = 0;
  logic [PPE_STATUS_W-1:0] rpn_err   = ST_OK;

  int unsigned queued_work    = 0;    // digits and operators queued so far
  int unsigned accepted_chars = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned status_tally [8];

  ppe_in_if  in_ch ();
  ppe_out_if out_ch ();

  assign in_ch.valid     = send_valid;
  assign in_ch.char_code = send_item.code;
  assign in_ch.last_char = send_item.last;
  assign out_ch.ready    = take_ready;

  postfix_expression_evaluator_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stack predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_digit(input logic [PPE_CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_operator(input logic [PPE_CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  // Keep only the first error of an expression.
  task automatic note_fault(input logic [PPE_STATUS_W-1:0] code);
    if (rpn_err == ST_OK) begin
      rpn_err = code;
    end
  endtask

  // A push into a full stack drops the value and flags overflow.
  task automatic push_operand(input logic [PPE_DATA_W-1:0] v);
    if (rpn_depth >= PPE_STACK_DEPTH) begin
      note_fault(ST_OVERFLOW);
    end else begin
      rpn_stack[rpn_depth] = v;
      rpn_depth++;
    end
  endtask

  // A pop from an empty stack reads as zero and flags underflow.
  task automatic pop_operand(output logic [PPE_DATA_W-1:0] v);
    if (rpn_depth == 0) begin
      note_fault(ST_UNDERFLOW);
      v = '0;
    end else begin
      rpn_depth--;
      v = rpn_stack[rpn_depth];
    end
  endtask

  // Divide magnitudes and fix the sign, so the quotient truncates toward zero
  // and the most negative value divided by minus one wraps onto itself.
  function automatic logic [PPE_DATA_W-1:0] quotient_toward_zero(
      input logic [PPE_DATA_W-1:0] num, input logic [PPE_DATA_W-1:0] den);
    logic [PPE_DATA_W-1:0] mag_n, mag_d, q;
    mag_n = num[PPE_DATA_W-1] ? -num : num;
    mag_d = den[PPE_DATA_W-1] ? -den : den;
    q     = mag_n / mag_d;
    return (num[PPE_DATA_W-1] ^ den[PPE_DATA_W-1]) ? -q : q;
  endfunction

  // Apply one accepted character; on the last one, queue the owed result.
  task automatic evaluate_char(input char_item_t it);
    logic [PPE_DATA_W-1:0] rhs, lhs, v;
    rpn_result_t res;
    if (is_digit(it.code)) begin
      push_operand(PPE_DATA_W'(it.code - CH_ZERO));
    end else if (is_operator(it.code)) begin
      pop_operand(rhs);
      pop_operand(lhs);
      case (it.code)
        CH_PLUS:  v = lhs + rhs;
        CH_MINUS: v = lhs - rhs;
        CH_STAR:  v = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            note_fault(ST_DIVZERO);
            v = '0;
          end else begin
            v = quotient_toward_zero(lhs, rhs);
          end
        end
      endcase
      push_operand(v);
    end
    if (it.last) begin
      if (rpn_depth == 0) begin
        note_fault(ST_EMPTY);
        res.value = '0;
      end else begin
        res.value = rpn_stack[rpn_depth-1];
      end
      res.status = rpn_err;
      expected_results.push_back(res);
      rpn_depth = 0;
      rpn_err   = ST_OK;
    end
  endtask

  task automatic log_mismatch(input string note);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, note);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the head of char_queue; hold it until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      send_valid <= 1'b0;
      send_item  <= '0;
    end else begin
      // The item on the wire was taken at this edge: predict and drop it.
      if (send_valid && in_ch.ready) begin
        evaluate_char(send_item);
        void'(char_queue.pop_front());
        accepted_chars++;
      end
      // Pick the next item only when the wire is free; a stalled item stays put.
      if (!send_valid || in_ch.ready) begin
        if (!pause_sender && char_queue.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          send_valid <= 1'b1;
          send_item  <= char_queue[0];
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results, compare with the oldest owed result, stall at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    rpn_result_t want;
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else begin
      if (out_ch.valid && take_ready) begin
        results_seen++;
        status_tally[out_ch.status]++;
        if (expected_results.size() == 0) begin
          log_mismatch($sformatf("result with none owed: value %0d status %0d",
                                 out_ch.result_value, out_ch.status));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_value !== want.value) begin
            log_mismatch($sformatf("result_value: expected %0d (0x%08h), got %0d (0x%08h)",
                                   $signed(want.value), want.value,
                                   out_ch.result_value, out_ch.result_value));
          end
          if (out_ch.status !== want.status) begin
            log_mismatch($sformatf("status: expected %0d, got %0d",
                                   want.status, out_ch.status));
          end
        end
      end
      take_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Expression builders. Each one fills draft; commit_draft marks the final
  // character as last and moves the expression to the send queue.
  // ---------------------------------------------------------------------------

  task automatic draft_char(input logic [PPE_CHAR_W-1:0] code, input logic last = 1'b0);
    char_item_t it;
    it.code = code;
    it.last = last;
    draft.push_back(it);
  endtask

  task automatic commit_draft();
    draft[draft.size()-1].last = 1'b1;
    foreach (draft[i]) begin
      char_queue.push_back(draft[i]);
      if (is_digit(draft[i].code) || is_operator(draft[i].code)) begin
        queued_work++;
      end
    end
    draft.delete();
  endtask

  function automatic logic [PPE_CHAR_W-1:0] any_digit();
    return ($urandom_range(3) == 0) ? CH_NINE : CH_ZERO + PPE_CHAR_W'($urandom_range(9));
  endfunction

  function automatic logic [PPE_CHAR_W-1:0] any_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Mostly blanks, otherwise any byte that is neither a digit nor an operator.
  function automatic logic [PPE_CHAR_W-1:0] ignored_char();
    logic [PPE_CHAR_W-1:0] c;
    c = 8'h20;
    if ($urandom_range(1) == 0) begin
      c = PPE_CHAR_W'($urandom_range(255));
      while (is_digit(c) || is_operator(c)) begin
        c = PPE_CHAR_W'($urandom_range(255));
      end
    end
    return c;
  endfunction

  // Well-formed expression: operators only when two values are on the stack,
  // reduced to one value at the end. Depth never passes the stack size.
  task automatic gen_well_formed();
    int unsigned left, depth;
    left  = ($urandom_range(3) == 0) ? $urandom_range(17, 7) : $urandom_range(6, 1);
    depth = 0;
    while (left > 0 || depth > 1) begin
      if (left > 0 && depth < PPE_STACK_DEPTH && (depth < 2 || $urandom_range(1) == 0)) begin
        draft_char(any_digit());
        left--;
        depth++;
      end else begin
        draft_char(any_operator());
        depth--;
      end
      if ($urandom_range(9) == 0) begin
        draft_char(ignored_char());
      end
    end
    if ($urandom_range(7) == 0) begin
      draft_char(ignored_char());
    end
    commit_draft();
  endtask

  // Push past a full stack, then a few operators (these never underflow).
  task automatic gen_overflow();
    int unsigned n_ops;
    repeat (PPE_STACK_DEPTH + $urandom_range(3, 1)) draft_char(any_digit());
    n_ops = $urandom_range(3);
    repeat (n_ops) draft_char(any_operator());
    commit_draft();
  endtask

  // Build 2 * 8**10, the most negative value, then maybe hit it with minus one:
  // quotient out of range, product wrap, step to the most positive value, or none.
  task automatic gen_most_negative();
    draft_char(CH_ZERO + 8'd2);
    repeat (10) begin
      draft_char(CH_ZERO + 8'd8);
      draft_char(CH_STAR);
    end
    case ($urandom_range(3))
      0: begin
        draft_char(CH_ZERO); draft_char(CH_ZERO + 8'd1); draft_char(CH_MINUS);
        draft_char(CH_SLASH);
      end
      1: begin
        draft_char(CH_ZERO); draft_char(CH_ZERO + 8'd1); draft_char(CH_MINUS);
        draft_char(CH_STAR);
      end
      2: begin
        draft_char(CH_ZERO + 8'd1); draft_char(CH_MINUS);
      end
      default: ;
    endcase
    commit_draft();
  endtask

  // Short operator-heavy runs that starve the stack.
  task automatic gen_broken();
    repeat ($urandom_range(8, 1)) begin
      if ($urandom_range(9) < 6) draft_char(any_operator());
      else                       draft_char(any_digit());
    end
    commit_draft();
  endtask

  // Raw bytes with stray last marks.
  task automatic gen_noise();
    repeat ($urandom_range(12, 1)) begin
      draft_char(PPE_CHAR_W'($urandom_range(255)), ($urandom_range(5) == 0));
    end
    commit_draft();
  endtask

  // One idling setting: queue enough work, hold the sender once midway until
  // every owed result is back, then drain.
  task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                           input int unsigned chars);
    int unsigned target, half, pick;
    @(negedge clk);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    target = queued_work + chars;
    while (queued_work < target) begin
      pick = $urandom_range(99);
      if (pick < 60)      gen_well_formed();
      else if (pick < 70) gen_overflow();
      else if (pick < 76) gen_most_negative();
      else if (pick < 88) gen_broken();
      else                gen_noise();
    end
    half = char_queue.size() / 2;
    while (char_queue.size() > half) @(negedge clk);
    pause_sender = 1'b1;
    while (send_valid || expected_results.size() != 0) @(negedge clk);
    pause_sender = 1'b0;
    while (send_valid || char_queue.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening.
    // Ignored byte alone: nothing on the stack at the end.
    draft_char(8'h00);
    commit_draft();
    // Largest digit, then an all-ones ignored byte as the last character.
    draft_char(CH_NINE); draft_char(8'hFF);
    commit_draft();
    // Negative result from subtraction.
    draft_char(CH_ZERO); draft_char(CH_NINE); draft_char(CH_MINUS);
    commit_draft();
    // Negative divided by positive truncates toward zero, then add.
    draft_char(CH_ZERO); draft_char(CH_NINE); draft_char(CH_MINUS);
    draft_char(CH_ZERO + 8'd2); draft_char(CH_SLASH);
    draft_char(CH_ZERO + 8'd5); draft_char(CH_PLUS);
    commit_draft();
    // Plain product.
    draft_char(CH_NINE); draft_char(CH_ZERO + 8'd3); draft_char(CH_STAR);
    commit_draft();
    // Operator on an empty stack.
    draft_char(CH_PLUS);
    commit_draft();
    // Divide by zero, then an underflow that must not replace the first error.
    draft_char(CH_ZERO + 8'd5); draft_char(CH_ZERO); draft_char(CH_SLASH);
    draft_char(CH_STAR);
    commit_draft();

    run_phase(11, 83, 350);
    run_phase(83, 11, 350);
    run_phase(0, 0, 370);

    while (expected_results.size() != 0) @(negedge clk);
    // Let a late or spurious result show up.
    repeat (48) @(negedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
    end
    $display("Covered %0d characters and %0d expression results (%0d mismatches)",
             accepted_chars, results_seen, mismatch_count);
    $display("By status: ok %0d, overflow %0d, underflow %0d, div-by-zero %0d, empty %0d",
             status_tally[ST_OK], status_tally[ST_OVERFLOW], status_tally[ST_UNDERFLOW],
             status_tally[ST_DIVZERO], status_tally[ST_EMPTY]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("Timeout with %0d characters queued and %0d results owed",
             char_queue.size(), expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
